// ===== src/dpm_pkg.sv =====
// ----------------------------------------------------------------------------
// dpm_pkg
// Shared widths, constants and types for the dense Prim MST engine.
// ----------------------------------------------------------------------------
package dpm_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = VIDX_W + 1;
	localparam int WEIGHT_BITS  = 16;
	localparam int COST_W       = WEIGHT_BITS + 1;
	localparam int TOTAL_W      = 22;
	localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
	localparam int MAT_AW       = 2 * VIDX_W;

	// top code of a link cost means "no edge"
	localparam logic [COST_W-1:0]  INF_COST  = {1'b1, {WEIGHT_BITS{1'b0}}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [VCNT_W-1:0]  N_MAX     = VCNT_W'(MAX_VERTICES);

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [VIDX_W-1:0] parent;
	} link_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_RELAX  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

endpackage

// ===== src/dense_prim_mst_engine_unit.sv =====
// ----------------------------------------------------------------------------
// dense_prim_mst_engine_unit
// Minimum spanning tree (Prim, dense form) over a loaded adjacency matrix.
// ----------------------------------------------------------------------------
// Matrix entries arrive one request per cycle on the s_ stream and go straight
// into a 4096 x 16 cost memory; every entry in use must be written first. The
// request with s_tlast set stores its entry and starts the tree computation
// from vertex 0 over vertex_count vertices (0 reads as 1, above 64 as 64).
// While computing, s_tready is low. Each of the n rounds takes a scan pass
// (one link-memory read per vertex, registered read data, a drain step) to
// find the cheapest vertex outside the tree, a decide step (held while the
// output register is still full), a relax pass (cost-memory and link-memory
// read per vertex, compare, write back) and a finish step. A run that meets
// an unreachable vertex stops at that round's decide step. One result per
// vertex joined after vertex 0 leaves on the m_ stream in joining order;
// m_tlast marks the final one. If a vertex turns out unreachable, one result
// with m_tuser (status) set, parent 0 and cost 0 ends the run. With one vertex
// no result is produced. The user must see that vertex_count is written
// through cfg_we/cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module dense_prim_mst_engine_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dpm_pkg::VCNT_W-1:0]      cfg_wdata,   // vertex_count
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [5:0] row, [11:6] col, [27:12] weight, rest zero
	input  logic [dpm_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tlast,     // last_entry
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [5:0] vertex, [11:6] parent, [27:12] edge_cost, [49:28] running_total
	output logic [dpm_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tuser,     // status: 1 disconnected
	output logic                            m_tlast      // last
);

	localparam int VW = dpm_pkg::VIDX_W;
	localparam int NW = dpm_pkg::VCNT_W;
	localparam int CW = dpm_pkg::COST_W;
	localparam int TW = dpm_pkg::TOTAL_W;
	localparam int WB = dpm_pkg::WEIGHT_BITS;

	dpm_pkg::state_t state_q;

	// config
	logic [NW-1:0] vcount_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] n_start;

	// input fields
	logic [VW-1:0] in_row, in_col;
	logic [WB-1:0] in_weight;
	logic          in_acc;

	// memories
	logic [WB-1:0]          cost_mem [dpm_pkg::MAT_DEPTH];
	logic [WB-1:0]          mat_rdata;
	logic [dpm_pkg::MAT_AW-1:0] mat_raddr;
	dpm_pkg::link_t         link_mem [dpm_pkg::MAX_VERTICES];
	dpm_pkg::link_t         link_rdata;
	logic                   link_we;
	logic [VW-1:0]          link_waddr;
	dpm_pkg::link_t         link_wdata;

	// per-vertex flags (flops)
	logic [dpm_pkg::MAX_VERTICES-1:0] in_tree_q;
	logic [dpm_pkg::MAX_VERTICES-1:0] link_vld_q;   // clear entry reads as infinity

	// pass control
	logic [NW-1:0] issue_q;
	logic          vld_s1;
	logic [VW-1:0] idx_s1;
	logic [NW-1:0] round_q;
	logic [VW-1:0] u_q;
	logic [VW-1:0] par_q;     // best-link parent of the scan winner
	logic [CW-1:0] best_q;
	logic          found_q;
	logic [TW-1:0] total_q;

	// datapath
	logic [CW-1:0] cur_cost;
	logic [CW-1:0] edge_w;
	logic          outside;
	logic          issue_more;
	logic [TW:0]   sum;
	logic [TW-1:0] sum_sat;
	logic          out_busy;

	// output register
	logic          out_vld_q;
	logic [VW-1:0] out_vertex_q, out_parent_q;
	logic [WB-1:0] out_cost_q;
	logic [TW-1:0] out_total_q;
	logic          out_status_q, out_last_q;

	assign in_row    = s_tdata[VW-1:0];
	assign in_col    = s_tdata[2*VW-1:VW];
	assign in_weight = s_tdata[2*VW+WB-1:2*VW];
	assign s_tready  = (state_q == dpm_pkg::ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;

	assign n_start = (vcount_q == '0) ? NW'(1) :
	                 (vcount_q > dpm_pkg::N_MAX) ? dpm_pkg::N_MAX : vcount_q;

	assign issue_more = (issue_q < n_q);
	assign mat_raddr  = {u_q, issue_q[VW-1:0]};
	assign outside    = !in_tree_q[idx_s1];
	assign cur_cost   = link_vld_q[idx_s1] ? link_rdata.cost : dpm_pkg::INF_COST;
	// zero off the diagonal is no edge
	assign edge_w     = (mat_rdata == '0 && idx_s1 != u_q) ? dpm_pkg::INF_COST :
	                    {1'b0, mat_rdata};

	assign sum     = {1'b0, total_q} + (TW+1)'(best_q);
	assign sum_sat = sum[TW] ? dpm_pkg::TOTAL_MAX : sum[TW-1:0];

	assign out_busy = out_vld_q && !m_tready;

	// link memory write: seed vertex 0 at start, relax updates later
	always_comb begin
		link_we    = 1'b0;
		link_waddr = idx_s1;
		link_wdata = '{cost: edge_w, parent: u_q};
		if (in_acc && s_tlast) begin
			link_we    = 1'b1;
			link_waddr = '0;
			link_wdata = '{cost: '0, parent: '0};
		end else if (state_q == dpm_pkg::ST_RELAX && vld_s1 && outside && edge_w < cur_cost) begin
			link_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			cost_mem[{in_row, in_col}] <= in_weight;
		mat_rdata <= cost_mem[mat_raddr];
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_waddr] <= link_wdata;
		link_rdata <= link_mem[issue_q[VW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= dpm_pkg::N_MAX;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dpm_pkg::ST_IDLE;
			n_q        <= dpm_pkg::N_MAX;
			issue_q    <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			round_q    <= '0;
			u_q        <= '0;
			par_q      <= '0;
			best_q     <= dpm_pkg::INF_COST;
			found_q    <= 1'b0;
			total_q    <= '0;
			in_tree_q  <= '0;
			link_vld_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_vld_q && m_tready)
				out_vld_q <= 1'b0;

			// read pipe: address issued this cycle, data seen next cycle
			vld_s1 <= 1'b0;
			idx_s1 <= issue_q[VW-1:0];

			unique case (state_q)
				dpm_pkg::ST_IDLE: begin
					if (in_acc && s_tlast) begin
						n_q        <= n_start;
						round_q    <= '0;
						total_q    <= '0;
						in_tree_q  <= '0;
						link_vld_q <= {{(dpm_pkg::MAX_VERTICES-1){1'b0}}, 1'b1};
						issue_q    <= '0;
						found_q    <= 1'b0;
						state_q    <= dpm_pkg::ST_SCAN;
					end
				end
				dpm_pkg::ST_SCAN: begin
					if (issue_more) begin
						issue_q <= issue_q + NW'(1);
						vld_s1  <= 1'b1;
					end
					// strict compare keeps the lowest index on ties
					if (vld_s1 && outside && (!found_q || cur_cost < best_q)) begin
						found_q <= 1'b1;
						best_q  <= cur_cost;
						u_q     <= idx_s1;
						par_q   <= link_rdata.parent;
					end
					if (!issue_more && !vld_s1)
						state_q <= dpm_pkg::ST_DECIDE;
				end
				dpm_pkg::ST_DECIDE: begin
					if (!found_q) begin
						state_q <= dpm_pkg::ST_IDLE;
					end else if (!out_busy) begin
						if (best_q[CW-1]) begin
							// unreachable vertex ends the run
							out_vld_q    <= 1'b1;
							out_vertex_q <= u_q;
							out_parent_q <= '0;
							out_cost_q   <= '0;
							out_total_q  <= total_q;
							out_status_q <= 1'b1;
							out_last_q   <= 1'b1;
							state_q      <= dpm_pkg::ST_IDLE;
						end else begin
							in_tree_q[u_q] <= 1'b1;
							if (round_q != '0) begin
								total_q      <= sum_sat;
								out_vld_q    <= 1'b1;
								out_vertex_q <= u_q;
								out_parent_q <= par_q;
								out_cost_q   <= best_q[WB-1:0];
								out_total_q  <= sum_sat;
								out_status_q <= 1'b0;
								out_last_q   <= (round_q + NW'(1) == n_q);
							end
							issue_q <= '0;
							state_q <= dpm_pkg::ST_RELAX;
						end
					end
				end
				dpm_pkg::ST_RELAX: begin
					if (issue_more) begin
						issue_q <= issue_q + NW'(1);
						vld_s1  <= 1'b1;
					end
					if (link_we)
						link_vld_q[idx_s1] <= 1'b1;
					if (!issue_more && !vld_s1)
						state_q <= dpm_pkg::ST_FINISH;
				end
				dpm_pkg::ST_FINISH: begin
					round_q <= round_q + NW'(1);
					issue_q <= '0;
					found_q <= 1'b0;
					state_q <= (round_q + NW'(1) >= n_q) ? dpm_pkg::ST_IDLE :
					           dpm_pkg::ST_SCAN;
				end
				default: begin
					state_q <= dpm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(dpm_pkg::OUT_DATA_W - 2*VW - WB - TW){1'b0}},
	                   out_total_q, out_cost_q, out_parent_q, out_vertex_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== tb/sv/dpm_mst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_mst_checker
// Mirrors the cost memory and vertex count, predicts each spanning-tree run
// and checks the result stream against it, in order, field by field.
// ----------------------------------------------------------------------------
module dpm_mst_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dpm_pkg::VCNT_W-1:0]      cfg_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [dpm_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tlast,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [dpm_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            m_tuser,
	input  logic                            m_tlast,
	output int                              fail_count,
	output int                              pending
);
	import dpm_pkg::*;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SPLIT = 1'b1;

	// result field offsets in m_tdata
	localparam int PAR_LO = VIDX_W;
	localparam int CST_LO = 2 * VIDX_W;
	localparam int TOT_LO = 2 * VIDX_W + WEIGHT_BITS;

	typedef struct {
		logic [VIDX_W-1:0]      vertex;
		logic [VIDX_W-1:0]      parent;
		logic [WEIGHT_BITS-1:0] cost;
		logic [TOTAL_W-1:0]     total;
		logic                   status;
		logic                   last;
	} tree_link_t;

	logic [WEIGHT_BITS-1:0] weight_mem [MAX_VERTICES][MAX_VERTICES];
	int                     node_count;
	tree_link_t             tree_q [$];

	initial fail_count = 0;

	task automatic flag(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// zero off the diagonal means no edge
	function automatic logic [COST_W-1:0] arc_cost(input int a, input int b);
		if (weight_mem[a][b] == '0 && a != b)
			return INF_COST;
		return {1'b0, weight_mem[a][b]};
	endfunction

	task automatic push_link(input int v, input int p, input logic [COST_W-1:0] c,
			input logic [TOTAL_W-1:0] t, input logic st, input logic lst);
		tree_link_t e;
		e.vertex = VIDX_W'(v);
		e.parent = VIDX_W'(p);
		e.cost   = c[WEIGHT_BITS-1:0];
		e.total  = t;
		e.status = st;
		e.last   = lst;
		tree_q.push_back(e);
	endtask

	// dense Prim from vertex 0, lowest index wins ties
	task automatic grow_tree();
		int                n;
		int                u;
		logic [COST_W-1:0] link_cost [MAX_VERTICES];
		int                link_par  [MAX_VERTICES];
		bit                joined    [MAX_VERTICES];
		logic [TOTAL_W:0]  total;
		logic [COST_W-1:0] w;
		n = node_count;
		if (n < 1)
			n = 1;
		if (n > MAX_VERTICES)
			n = MAX_VERTICES;
		for (int v = 0; v < MAX_VERTICES; v++) begin
			link_cost[v] = INF_COST;
			link_par[v]  = 0;
			joined[v]    = 1'b0;
		end
		link_cost[0] = '0;
		total = '0;
		for (int rnd = 0; rnd < n; rnd++) begin
			u = -1;
			for (int v = 0; v < n; v++)
				if (!joined[v] && (u < 0 || link_cost[v] < link_cost[u]))
					u = v;
			if (u < 0)
				break;
			if (link_cost[u] >= INF_COST) begin
				push_link(u, 0, '0, total[TOTAL_W-1:0], STATUS_SPLIT, 1'b1);
				return;
			end
			joined[u] = 1'b1;
			if (rnd > 0) begin
				total = total + link_cost[u];
				if (total > TOTAL_MAX)
					total = TOTAL_MAX;
				push_link(u, link_par[u], link_cost[u], total[TOTAL_W-1:0], STATUS_OK,
					rnd == n - 1);
			end
			for (int v = 0; v < n; v++) begin
				w = arc_cost(u, v);
				if (!joined[v] && w < link_cost[v]) begin
					link_cost[v] = w;
					link_par[v]  = u;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input longint unsigned got,
			input longint unsigned want, input longint unsigned vtx);
		if (got != want)
			flag($sformatf("vertex %0d %s: got %0d, want %0d", vtx, name, got, want));
	endtask

	task automatic check_result();
		tree_link_t want;
		if (tree_q.size() == 0) begin
			flag($sformatf("result for vertex %0d with nothing pending", m_tdata[VIDX_W-1:0]));
			return;
		end
		want = tree_q.pop_front();
		check_field("vertex", m_tdata[VIDX_W-1:0], want.vertex, want.vertex);
		check_field("parent", m_tdata[PAR_LO +: VIDX_W], want.parent, want.vertex);
		check_field("edge cost", m_tdata[CST_LO +: WEIGHT_BITS], want.cost, want.vertex);
		check_field("running total", m_tdata[TOT_LO +: TOTAL_W], want.total, want.vertex);
		check_field("status", m_tuser, want.status, want.vertex);
		check_field("last", m_tlast, want.last, want.vertex);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count = MAX_VERTICES;
			tree_q.delete();
			pending <= 0;
		end else begin
			// older results first, then whatever the new request adds
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_we)
				node_count = int'(cfg_wdata);
			if (s_tvalid && s_tready) begin
				weight_mem[s_tdata[VIDX_W-1:0]][s_tdata[VIDX_W +: VIDX_W]] =
					s_tdata[2*VIDX_W +: WEIGHT_BITS];
				if (s_tlast)
					grow_tree();
			end
			pending <= tree_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_dense_prim_mst_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dense_prim_mst_engine_unit
// Loads adjacency matrices into the MST engine and checks the tree it emits.
// ----------------------------------------------------------------------------
// A short directed part covers the single-vertex run, the widest weights, a
// two-vertex split, equal costs and a vertex left unreachable behind a
// reachable one. Random runs follow on small graphs (wide, tie-heavy, sparse
// and split weights, some one-way edges, stray writes, the last mark off the
// graph). Both streams idle at random. The checker beside the engine predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_dense_prim_mst_engine_unit;
	import dpm_pkg::*;

	localparam int IDLE_LIMIT     = 4000;   // cycles with no request moving
	localparam int RANDOM_ENTRIES = 230;
	localparam int W_TOP          = (1 << WEIGHT_BITS) - 1;

	typedef enum int {
		GRAPH_WIDE,     // full weight range, a few missing edges
		GRAPH_TIES,     // costs 1..3, lots of equal candidates
		GRAPH_SPARSE,   // mostly missing edges
		GRAPH_SPLIT     // two vertex groups with no edge between them
	} graph_kind_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [VCNT_W-1:0]       cfg_wdata = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata   = '0;
	logic                    s_tlast   = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    m_tuser;
	logic                    m_tlast;

	int fails;
	int pending;

	bit no_idle      = 1'b0;   // phases with both streams running flat out
	int ready_hold   = 0;
	int stall;
	int quiet_cycles = 0;
	int last_n       = MAX_VERTICES;   // vertex count in force, after clamping
	int entries_sent = 0;

	// entries written so far: a run never reads one that was not
	bit filled [MAX_VERTICES][MAX_VERTICES];
	// group of each vertex for split graphs, vertex 0 always in group 0
	bit side   [MAX_VERTICES];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	dense_prim_mst_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	dpm_mst_checker mst_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fails),
		.pending    (pending)
	);

	// idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] pick_weight(input graph_kind_t kind,
			input int a, input int b);
		int r;
		// diagonal is stored but never taken as an edge
		if (a == b)
			return WEIGHT_BITS'($urandom_range(0, W_TOP));
		if (kind == GRAPH_SPLIT && side[a] != side[b])
			return '0;
		r = $urandom_range(0, 99);
		case (kind)
			GRAPH_TIES: begin
				if (r < 10)
					return '0;
				return WEIGHT_BITS'($urandom_range(1, 3));
			end
			GRAPH_SPARSE: begin
				if (r < 65)
					return '0;
				return WEIGHT_BITS'($urandom_range(1, W_TOP));
			end
			default: begin
				if (r < 8)
					return '0;
				if (r < 16)
					return WEIGHT_BITS'(W_TOP);
				if (r < 22)
					return WEIGHT_BITS'(1);
				return WEIGHT_BITS'($urandom_range(1, W_TOP));
			end
		endcase
	endfunction

	// one matrix entry request; valid drops only for a gap or after the last mark
	task automatic put_entry(input int r, input int c, input logic [WEIGHT_BITS-1:0] w,
			input bit lst);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({w, VIDX_W'(c), VIDX_W'(r)});
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		filled[r][c] = 1'b1;
		entries_sent++;
		if (lst)
			s_tvalid <= 1'b0;
	endtask

	// vertex count changes only once results are drained and the engine is idle
	task automatic set_vertex_count(input int val);
		do @(posedge clk); while (pending != 0 || !s_tready);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= VCNT_W'(val);
		@(posedge clk);
		cfg_we    <= 1'b0;
		last_n = (val == 0) ? 1 : ((val > MAX_VERTICES) ? MAX_VERTICES : val);
	endtask

	// one graph: every entry in use gets written at least once, most get fresh
	// content, a few edges go one way only
	task automatic run_graph(input int cfg_val, input graph_kind_t kind,
			input bit mark_outside);
		int                     n;
		int                     r;
		int                     c;
		logic [WEIGHT_BITS-1:0] w_fwd;
		logic [WEIGHT_BITS-1:0] w_rev;
		set_vertex_count(cfg_val);
		n = last_n;
		for (int v = 0; v < MAX_VERTICES; v++)
			side[v] = (v != 0) && ($urandom_range(0, 1) == 1);
		for (int a = 0; a < n; a++) begin
			for (int b = a; b < n; b++) begin
				if (filled[a][b] && filled[b][a] && kind != GRAPH_SPLIT &&
						$urandom_range(0, 3) == 0)
					continue;
				w_fwd = pick_weight(kind, a, b);
				w_rev = ($urandom_range(0, 9) == 0) ? pick_weight(kind, b, a) : w_fwd;
				put_entry(a, b, w_fwd, 1'b0);
				if (a != b)
					put_entry(b, a, w_rev, 1'b0);
			end
		end
		if (kind != GRAPH_SPLIT)
			repeat ($urandom_range(0, 2))
				put_entry($urandom_range(0, MAX_VERTICES - 1),
					$urandom_range(0, MAX_VERTICES - 1),
					WEIGHT_BITS'($urandom_range(0, W_TOP)), 1'b0);
		// the last mark may sit on an entry the run never reads
		if (mark_outside && n < MAX_VERTICES)
			r = $urandom_range(n, MAX_VERTICES - 1);
		else
			r = $urandom_range(0, n - 1);
		c = $urandom_range(0, n - 1);
		put_entry(r, c, pick_weight(kind, r, c), 1'b1);
	endtask

	// result side: ready stretches broken by stalls of random length
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!m_tready || no_idle) begin
			m_tready   <= 1'b1;
			ready_hold <= $urandom_range(0, 20);
		end else begin
			stall = gap_len();
			if (stall > 0) begin
				m_tready   <= 1'b0;
				ready_hold <= stall - 1;
			end else begin
				ready_hold <= $urandom_range(0, 20);
			end
		end
	end

	// watchdog: too long without any request moving on either side
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_dense_prim_mst_engine_unit failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int          cfg_val;
		int          r;
		int          left;
		int          random_start;
		graph_kind_t kind;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// count 0 reads as one vertex: stores its entry, no result
		set_vertex_count(0);
		put_entry(0, 0, WEIGHT_BITS'(W_TOP), 1'b1);

		// two vertices joined by the widest weight
		set_vertex_count(2);
		put_entry(0, 0, '0, 1'b0);
		put_entry(0, 1, WEIGHT_BITS'(W_TOP), 1'b0);
		put_entry(1, 0, WEIGHT_BITS'(W_TOP), 1'b0);
		put_entry(1, 1, '0, 1'b1);

		// same pair, edge removed: vertex 1 reported unreachable
		set_vertex_count(2);
		put_entry(0, 1, '0, 1'b0);
		put_entry(1, 0, '0, 1'b0);
		put_entry(1, 1, WEIGHT_BITS'(7), 1'b1);

		// three vertices, all costs equal: lowest index must win
		set_vertex_count(3);
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				put_entry(a, b, (a == b) ? '0 : WEIGHT_BITS'(1), a == 2 && b == 2);

		// vertex 2 joins, then vertex 1 has no way in
		set_vertex_count(3);
		put_entry(0, 1, '0, 1'b0);
		put_entry(1, 0, '0, 1'b0);
		put_entry(1, 2, '0, 1'b0);
		put_entry(2, 1, '0, 1'b0);
		put_entry(0, 2, WEIGHT_BITS'(3), 1'b1);

		// random small graphs; larger ones only while the budget allows
		random_start = entries_sent;
		while (entries_sent - random_start < RANDOM_ENTRIES) begin
			left = RANDOM_ENTRIES - (entries_sent - random_start);
			r = $urandom_range(0, 99);
			if (r < 8)
				cfg_val = $urandom_range(0, 1);
			else if (r < 15 && left > 150)
				cfg_val = $urandom_range(9, 12);
			else
				cfg_val = $urandom_range(2, 8);
			kind = graph_kind_t'($urandom_range(0, 3));
			no_idle <= ($urandom_range(0, 3) == 0);
			run_graph(cfg_val, kind, $urandom_range(0, 4) == 0);
		end

		// drain, then leave room for anything stray to show up
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		if (fails == 0)
			$display("tb_dense_prim_mst_engine_unit passed");
		else
			$display("tb_dense_prim_mst_engine_unit failed");
		$finish;
	end

endmodule
